// ----- rtl/rbpp_pkg.sv -----
// Shared types and constants for the ring buffered packet parser.
`timescale 1ns / 1ps
package rbpp_pkg;

   localparam int MAX_WORDS   = 7;
   localparam int QUEUE_DEPTH = 4;
   localparam int QW          = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      KIND_PUSH     = 2'd0,
      KIND_WORD     = 2'd1,
      KIND_NONE     = 2'd2,
      KIND_MISMATCH = 2'd3
   } kind_type;

   typedef enum logic {
      OP_PUSH  = 1'b0,
      OP_PARSE = 1'b1
   } op_type;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        overflow;
      logic [31:0] word;
      logic [2:0]  word_index;
      logic        last;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } cmd_type;

endpackage

// ----- rtl/rbpp_ram.sv -----
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps
module rbpp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rbpp_front.sv -----
// Front end: accepts request beats, decodes them and queues commands.
`timescale 1ns / 1ps
module rbpp_front
   import rbpp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   cmd_type       q_ff [QUEUE_DEPTH];
   logic [QW-1:0] head_ff, head_in;
   logic [QW-1:0] tail_ff, tail_in;
   logic [QW:0]   cnt_ff, cnt_in;
   logic          full;
   logic          push;
   logic          pop;
   cmd_type       decoded;

   assign full      = (cnt_ff == (QW+1)'(QUEUE_DEPTH));
   assign req_stall = full;
   assign push      = req_valid && !full;
   assign cmd_valid = (cnt_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = q_ff[head_ff];

   always_comb begin
      decoded.op   = req_payload.action ? OP_PARSE : OP_PUSH;
      decoded.data = req_payload.rx_byte;
   end

   always_comb begin
      head_in = pop  ? head_ff + 1'b1 : head_ff;
      tail_in = push ? tail_ff + 1'b1 : tail_ff;
      cnt_in  = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[tail_ff] <= decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QW+1)'(QUEUE_DEPTH))
      else $error("command queue count out of range");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != (QW+1)'(QUEUE_DEPTH)) |-> (QW'(tail_ff - head_ff) == cnt_ff[QW-1:0]))
      else $error("command queue pointers disagree with count");
   a_pop_moves_head: assert property (@(posedge clock) disable iff (reset)
      pop |=> (head_ff == $past(head_ff) + 1'b1))
      else $error("pop did not advance head");
`endif

endmodule

// ----- rtl/rbpp_engine.sv -----
// Back end: receive ring, header search, checksum check and word output.
`timescale 1ns / 1ps
module rbpp_engine
   import rbpp_pkg::*;
#(
   parameter int RING_DEPTH   = 128,
   parameter int PACKET_BYTES = 31
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] header_byte,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload
);

   localparam int PW     = $clog2(RING_DEPTH);
   localparam int OW     = $clog2(PACKET_BYTES + 1);
   localparam int NWORDS = (PACKET_BYTES / 4 > MAX_WORDS) ? MAX_WORDS : PACKET_BYTES / 4;
   localparam logic [PW:0] DEPTH_EXT = (PW+1)'(RING_DEPTH);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_PUSH      = 9'b000000010,
      ST_SKIP_RD   = 9'b000000100,
      ST_SKIP_CHK  = 9'b000001000,
      ST_SUM       = 9'b000010000,
      ST_WORD_RD   = 9'b000100000,
      ST_WORD_DAT  = 9'b001000000,
      ST_WORD_EMIT = 9'b010000000,
      ST_RESULT    = 9'b100000000
   } state_type;

   function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] base,
                                              input logic [PW:0] inc);
      logic [PW:0] s;
      s = {1'b0, base} + inc;
      if (s >= DEPTH_EXT) begin
         s = s - DEPTH_EXT;
      end
      return s[PW-1:0];
   endfunction

   state_type   state_ff, state_in;
   logic [PW-1:0] wp_ff, wp_in;
   logic [PW-1:0] rp_ff, rp_in;
   logic [7:0]    byte_ff, byte_in;
   logic [OW-1:0] off_ff, off_in;
   logic [OW-1:0] dat_off_ff;
   logic          dat_vld_ff;
   logic [15:0]   sum_ff, sum_in;
   logic [7:0]    trail_hi_ff, trail_hi_in;
   logic [31:0]   word_ff, word_in;
   logic [1:0]    bcnt_ff, bcnt_in;
   logic [2:0]    widx_ff, widx_in;
   kind_type      kind_ff, kind_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff, rsp_in;

   logic [PW-1:0] count;
   logic          enough;
   logic [PW-1:0] wp_inc;
   logic          ring_full;
   logic          out_free;
   logic          out_load;
   logic          ram_we;
   logic          rd_en;
   logic [PW-1:0] rd_addr;
   logic [OW-1:0] rd_off;
   logic [7:0]    rd_data;
   logic          last_word;

   always_comb begin
      if (wp_ff >= rp_ff) begin
         count = wp_ff - rp_ff;
      end else begin
         count = PW'(({1'b0, wp_ff} + DEPTH_EXT) - {1'b0, rp_ff});
      end
   end

   assign enough    = (count > PW'(PACKET_BYTES));
   assign wp_inc    = ring_add(wp_ff, (PW+1)'(1));
   assign ring_full = (wp_inc == rp_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_word = (widx_ff == 3'(NWORDS - 1));
   assign out_load  = out_free && (state_ff == ST_PUSH || state_ff == ST_RESULT ||
                                   state_ff == ST_WORD_EMIT);
   assign ram_we    = out_free && (state_ff == ST_PUSH);
   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid;

   assign rd_off  = (state_ff == ST_SKIP_RD) ? '0 : off_ff;
   assign rd_addr = ring_add(rp_ff, (PW+1)'(rd_off));
   assign rd_en   = ((state_ff == ST_SKIP_RD) && enough) ||
                    ((state_ff == ST_SUM) && (off_ff < OW'(PACKET_BYTES))) ||
                    (state_ff == ST_WORD_RD);

   rbpp_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (byte_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      byte_in     = byte_ff;
      off_in      = off_ff;
      sum_in      = sum_ff;
      trail_hi_in = trail_hi_ff;
      word_in     = word_ff;
      bcnt_in     = bcnt_ff;
      widx_in     = widx_ff;
      kind_in     = kind_ff;
      rsp_in      = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               byte_in = cmd.data;
               if (cmd.op == OP_PUSH) begin
                  state_in = ST_PUSH;
               end else begin
                  state_in = ST_SKIP_RD;
               end
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               if (!ring_full) begin
                  wp_in = wp_inc;
               end
               rsp_in.kind       = KIND_PUSH;
               rsp_in.overflow   = ring_full;
               rsp_in.word       = '0;
               rsp_in.word_index = '0;
               rsp_in.last       = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         ST_SKIP_RD: begin
            if (enough) begin
               state_in = ST_SKIP_CHK;
            end else begin
               kind_in  = KIND_NONE;
               state_in = ST_RESULT;
            end
         end
         ST_SKIP_CHK: begin
            if (rd_data == header_byte) begin
               off_in   = '0;
               sum_in   = '0;
               state_in = ST_SUM;
            end else begin
               rp_in    = ring_add(rp_ff, (PW+1)'(1));
               state_in = ST_SKIP_RD;
            end
         end
         ST_SUM: begin
            if (off_ff < OW'(PACKET_BYTES)) begin
               off_in = off_ff + 1'b1;
            end
            if (dat_vld_ff) begin
               if (dat_off_ff < OW'(PACKET_BYTES - 2)) begin
                  sum_in = sum_ff + 16'(rd_data);
               end
               if (dat_off_ff == OW'(PACKET_BYTES - 2)) begin
                  trail_hi_in = rd_data;
               end
               if (dat_off_ff == OW'(PACKET_BYTES - 1)) begin
                  if (sum_ff == {trail_hi_ff, rd_data}) begin
                     off_in   = OW'(1);
                     bcnt_in  = '0;
                     widx_in  = '0;
                     state_in = ST_WORD_RD;
                  end else begin
                     rp_in    = ring_add(rp_ff, (PW+1)'(1));
                     kind_in  = KIND_MISMATCH;
                     state_in = ST_RESULT;
                  end
               end
            end
         end
         ST_WORD_RD: begin
            off_in   = off_ff + 1'b1;
            state_in = ST_WORD_DAT;
         end
         ST_WORD_DAT: begin
            word_in = {word_ff[23:0], rd_data};
            bcnt_in = bcnt_ff + 1'b1;
            if (bcnt_ff == 2'd3) begin
               state_in = ST_WORD_EMIT;
            end else begin
               state_in = ST_WORD_RD;
            end
         end
         ST_WORD_EMIT: begin
            if (out_free) begin
               rsp_in.kind       = KIND_WORD;
               rsp_in.overflow   = 1'b0;
               rsp_in.word       = word_ff;
               rsp_in.word_index = widx_ff;
               rsp_in.last       = last_word;
               if (last_word) begin
                  rp_in    = ring_add(rp_ff, (PW+1)'(PACKET_BYTES));
                  state_in = ST_IDLE;
               end else begin
                  widx_in  = widx_ff + 1'b1;
                  state_in = ST_WORD_RD;
               end
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_in.kind       = kind_ff;
               rsp_in.overflow   = 1'b0;
               rsp_in.word       = '0;
               rsp_in.word_index = '0;
               rsp_in.last       = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      off_ff      <= off_in;
      dat_off_ff  <= off_ff;
      sum_ff      <= sum_in;
      trail_hi_ff <= trail_hi_in;
      word_ff     <= word_in;
      bcnt_ff     <= bcnt_in;
      widx_ff     <= widx_in;
      kind_ff     <= kind_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         dat_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wp_ff      <= wp_in;
         rp_ff      <= rp_in;
         dat_vld_ff <= (state_ff == ST_SUM) && (off_ff < OW'(PACKET_BYTES));
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_wp_only_on_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_PUSH) |=> (wp_ff == $past(wp_ff)))
      else $error("write pointer moved outside a push");
   a_overflow_holds_wp: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ring_full) |=> (wp_ff == $past(wp_ff)))
      else $error("write pointer advanced on a full ring");
   a_ring_not_full_after: assert property (@(posedge clock) disable iff (reset)
      (wp_ff != rp_ff) |=> (wp_ff != rp_ff))
      else $error("ring pointers collided");
   a_word_index_range: assert property (@(posedge clock) disable iff (reset)
      (out_load && state_ff == ST_WORD_EMIT) |-> (widx_ff < 3'(NWORDS)))
      else $error("word index beyond packet");
   a_no_load_while_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !out_load)
      else $error("result overwritten while stalled");
`endif

endmodule

// ----- rtl/ring_buffered_packet_parser.sv -----
// Top level: header register, command queue and parse engine.
//
//   channel | direction | handshake         | beat
//   req     | in        | req_valid/stall   | req_type: action, rx_byte
//   rsp     | out       | rsp_valid/stall   | rsp_type: kind, overflow, word, word_index, last
//   csr     | in        | csr_valid/ready   | header_byte
//
// A push passes from the queue head through ST_IDLE and ST_PUSH to its result. A parse
// visits ST_SKIP_RD and ST_SKIP_CHK for each byte skipped in the header search, ST_SUM
// for the checksum pass, and ST_WORD_RD/ST_WORD_DAT per byte then ST_WORD_EMIT per word.
// Reset clears the pointers, queue and header register; ring contents stay unknown.
// A stalled result holds in the output register while the queue takes beats until full.
`timescale 1ns / 1ps
module ring_buffered_packet_parser
   import rbpp_pkg::*;
#(
   parameter int RING_DEPTH   = 128,
   parameter int PACKET_BYTES = 31
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   logic [7:0] header_ff;
   logic       cmd_valid;
   cmd_type    cmd;
   logic       cmd_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         header_ff <= csr_data;
      end
   end

   rbpp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   rbpp_engine #(
      .RING_DEPTH   (RING_DEPTH),
      .PACKET_BYTES (PACKET_BYTES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .header_byte (header_ff),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- bench/tb_ring_buffered_packet_parser.sv -----
// Testbench for the ring buffered packet parser: directed and random beats against a predictor.
`timescale 1ns / 1ps
module tb_ring_buffered_packet_parser;
   import rbpp_pkg::*;

   localparam int RING_DEPTH   = 128;
   localparam int PACKET_BYTES = 31;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = '0;

   ring_buffered_packet_parser #(
      .RING_DEPTH   (RING_DEPTH),
      .PACKET_BYTES (PACKET_BYTES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #1 clock = ~clock;

   // predictor state
   logic [7:0] ring_image [RING_DEPTH];
   logic [6:0] wr_ptr = '0;
   logic [6:0] rd_ptr = '0;
   logic [7:0] header_shadow = '0;
   rsp_type    due_rsp[$];

   int  error_count = 0;
   int  beat_count = 0;
   int  stall_left = 0;
   bit  req_idle = 1'b0;
   bit  rsp_idle = 1'b0;
   rsp_type want;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void predict_parser_beat(op_type op, logic [7:0] rx);
      logic [6:0]  nxt;
      logic [6:0]  diff;
      int          fill;
      int          nwords;
      logic [15:0] csum;
      logic [15:0] trailer;
      logic [31:0] w;
      if (op == OP_PUSH) begin
         ring_image[wr_ptr] = rx;
         nxt = wr_ptr + 7'd1;
         if (nxt == rd_ptr) begin
            due_rsp.push_back('{kind: KIND_PUSH, overflow: 1'b1, word: '0,
                                word_index: '0, last: 1'b1});
         end else begin
            wr_ptr = nxt;
            due_rsp.push_back('{kind: KIND_PUSH, overflow: 1'b0, word: '0,
                                word_index: '0, last: 1'b1});
         end
         return;
      end
      diff = wr_ptr - rd_ptr;
      fill = int'(diff);
      while (fill > PACKET_BYTES && ring_image[rd_ptr] != header_shadow) begin
         rd_ptr = rd_ptr + 7'd1;
         fill--;
      end
      if (fill <= PACKET_BYTES || ring_image[rd_ptr] != header_shadow) begin
         due_rsp.push_back('{kind: KIND_NONE, overflow: 1'b0, word: '0,
                             word_index: '0, last: 1'b1});
         return;
      end
      csum = '0;
      for (int i = 0; i < PACKET_BYTES - 2; i++)
         csum = csum + 16'(ring_image[rd_ptr + 7'(i)]);
      trailer = {ring_image[rd_ptr + 7'(PACKET_BYTES - 2)],
                 ring_image[rd_ptr + 7'(PACKET_BYTES - 1)]};
      if (csum != trailer) begin
         rd_ptr = rd_ptr + 7'd1;
         due_rsp.push_back('{kind: KIND_MISMATCH, overflow: 1'b0, word: '0,
                             word_index: '0, last: 1'b1});
         return;
      end
      nwords = PACKET_BYTES / 4;
      if (nwords > MAX_WORDS) nwords = MAX_WORDS;
      for (int wi = 0; wi < nwords; wi++) begin
         w = '0;
         for (int j = 0; j < 4; j++)
            w = {w[23:0], ring_image[rd_ptr + 7'(1 + 4 * wi + j)]};
         due_rsp.push_back('{kind: KIND_WORD, overflow: 1'b0, word: w,
                             word_index: 3'(wi), last: (wi + 1 == nwords)});
      end
      rd_ptr = rd_ptr + 7'(PACKET_BYTES);
   endfunction

   task automatic send_beat(input op_type op, input logic [7:0] rx);
      int gap;
      gap = req_idle ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{action: op, rx_byte: rx};
      do @(posedge clock); while (req_stall);
      predict_parser_beat(op, rx);
      beat_count++;
   endtask

   task automatic settle_parser();
      req_valid <= 1'b0;
      while (due_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_header(input logic [7:0] value);
      settle_parser();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      header_shadow = value;
   endtask

   task automatic push_packet(input bit corrupt);
      logic [7:0]  pkt [PACKET_BYTES];
      logic [15:0] csum;
      pkt[0] = header_shadow;
      csum = 16'(header_shadow);
      for (int i = 1; i < PACKET_BYTES - 2; i++) begin
         pkt[i] = 8'($urandom_range(0, 255));
         csum = csum + 16'(pkt[i]);
      end
      if (corrupt) csum = csum ^ 16'($urandom_range(1, 16'hFFFF));
      pkt[PACKET_BYTES - 2] = csum[15:8];
      pkt[PACKET_BYTES - 1] = csum[7:0];
      for (int i = 0; i < PACKET_BYTES; i++) send_beat(OP_PUSH, pkt[i]);
   endtask

   task automatic push_noise(input int n);
      for (int i = 0; i < n; i++) send_beat(OP_PUSH, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_short_buffer();
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      write_header(8'h00);
      send_beat(OP_PARSE, 8'h00);
      send_beat(OP_PUSH, 8'h00);
      send_beat(OP_PUSH, 8'hFF);
      send_beat(OP_PARSE, 8'hFF);
   endtask

   task automatic test_header_hunt();
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      write_header(8'hFF);
      for (int i = 0; i < PACKET_BYTES + 2; i++)
         send_beat(OP_PUSH, 8'($urandom_range(0, 254)));
      send_beat(OP_PARSE, 8'($urandom_range(0, 255)));
      push_packet(1'b0);
      push_noise(1);
      send_beat(OP_PARSE, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_bad_checksum();
      push_packet(1'b1);
      push_noise(1);
      send_beat(OP_PARSE, 8'h00);
      send_beat(OP_PARSE, 8'h00);
   endtask

   task automatic test_ring_overflow();
      write_header(8'hA5);
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      for (int p = 0; p < 4; p++) push_packet(1'b0);
      push_noise(6);
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      for (int i = 0; i < 6; i++) send_beat(OP_PARSE, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_mixed_stream();
      int start;
      int r;
      write_header(8'($urandom_range(1, 254)));
      start = beat_count;
      while (beat_count - start < 20) begin
         r = $urandom_range(0, 9);
         if (r < 6) begin
            push_noise($urandom_range(0, 2));
            push_packet(1'b0);
         end else if (r < 8) begin
            push_packet(1'b1);
         end else begin
            push_noise($urandom_range(1, 8));
         end
         repeat ($urandom_range(1, 2)) send_beat(OP_PARSE, 8'($urandom_range(0, 255)));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_rsp.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result beat: kind %0d ovf %0b word %h idx %0d last %0b",
                        rsp_payload.kind, rsp_payload.overflow, rsp_payload.word,
                        rsp_payload.word_index, rsp_payload.last);
         end else begin
            want = due_rsp.pop_front();
            if (rsp_payload.kind !== want.kind || rsp_payload.overflow !== want.overflow ||
                rsp_payload.word !== want.word || rsp_payload.word_index !== want.word_index ||
                rsp_payload.last !== want.last) begin
               error_count++;
               if (error_count <= 10)
                  $display("result mismatch: exp kind %0d ovf %0b word %h idx %0d last %0b",
                           want.kind, want.overflow, want.word, want.word_index, want.last,
                           " / got kind %0d ovf %0b word %h idx %0d last %0b",
                           rsp_payload.kind, rsp_payload.overflow, rsp_payload.word,
                           rsp_payload.word_index, rsp_payload.last);
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left = rsp_idle ? pick_gap() : 0;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_buffer();
      test_header_hunt();
      test_bad_checksum();
      test_ring_overflow();
      test_mixed_stream();
      settle_parser();
      repeat (60) @(posedge clock);
      if (error_count == 0 && due_rsp.size() == 0) begin
         $display("ring_buffered_packet_parser regression: pass");
      end else begin
         $display("ring_buffered_packet_parser regression: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("ring_buffered_packet_parser regression: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/rbpp_pkg.sv
rtl/rbpp_ram.sv
rtl/rbpp_front.sv
rtl/rbpp_engine.sv
rtl/ring_buffered_packet_parser.sv
bench/tb_ring_buffered_packet_parser.sv
